// ===== rtl/ooaf_pkg.sv =====
// Shared constants for the overwrite-oldest acknowledge FIFO.
// Used by overwrite_oldest_ack_fifo_unit; no dependencies.
package ooaf_pkg;

	localparam int MAX_DEPTH = 256;
	localparam int PTR_W     = $clog2(MAX_DEPTH);
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int DATA_W    = 8;
	localparam int ACTION_W  = 2;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;

	localparam logic [DATA_W-1:0] EXC_CODE = 8'h70;

	// register index, taken from paddr[2]
	localparam logic REG_DEPTH  = 1'b0;
	localparam logic REG_EXC_EN = 1'b1;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(MAX_DEPTH);

endpackage

// ===== rtl/overwrite_oldest_ack_fifo_unit.sv =====
// Overwrite-oldest byte FIFO with two-phase (read, then acknowledge) reads.
// Depends on ooaf_pkg.
//
// Each transfer on the input channel runs through ST_IDLE and ST_EXEC: the head
// entry of the entry memory is read in the accept cycle, and the read-modify-write
// of the entry and pointers completes in ST_EXEC, where the result is loaded into
// the output register; ST_EXEC waits while a finished result still blocks the
// output register. The input side is stalled throughout ST_EXEC, so a new item is
// not taken before the last one is through. Entry valid bits in flip-flops make
// the memory read as zero after reset; no clearing pass is needed.
module overwrite_oldest_ack_fifo_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB-style register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ooaf_pkg::PADDR_W-1:0]   paddr,
	input  logic [ooaf_pkg::PDATA_W-1:0]   pwdata,
	output logic [ooaf_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ooaf_pkg::ACTION_W-1:0]  action,
	input  logic [ooaf_pkg::DATA_W-1:0]    data,
	// output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ooaf_pkg::DATA_W-1:0]    read_data,
	output logic                           has_data,
	output logic                           ack_pending,
	output logic                           exception_pending
);
	import ooaf_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                 state_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic                 exc_en_q;

	logic [PTR_W-1:0]     wp_q, rp_q;
	logic                 wrapped_q, ovw_q, ack_q, exc_q;

	logic [DATA_W-1:0]    mem [MAX_DEPTH];
	logic [MAX_DEPTH-1:0] entry_valid_q;

	logic [ACTION_W-1:0]  action_s1;
	logic [DATA_W-1:0]    data_s1;
	logic [DATA_W-1:0]    mem_rd_s1;
	logic                 rd_valid_s1;

	logic                 out_valid_q;
	logic [DATA_W-1:0]    read_data_q;
	logic                 has_data_q, ack_pending_q, exc_pending_q;

	logic                 in_xfer, cfg_wr, exec_done;
	logic [PTR_W-1:0]     last;
	logic [DEPTH_W-1:0]   depth_eff;
	logic [DATA_W-1:0]    head;

	logic [PTR_W-1:0]     wp_n, rp_n, wp_prev_n, wp_prev;
	logic                 wrapped_n, ovw_n, ack_n, exc_n;
	logic [DATA_W-1:0]    rd_n;
	logic                 mem_we;
	logic [PTR_W-1:0]     mem_waddr;
	logic [DATA_W-1:0]    mem_wdata;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_EXC_EN) begin
			prdata[0] = exc_en_q;
		end else begin
			prdata[DEPTH_W-1:0] = depth_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= DEPTH_RESET;
			exc_en_q <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_EXC_EN) begin
				exc_en_q <= pwdata[0];
			end else begin
				depth_q <= pwdata[DEPTH_W-1:0];
			end
		end
	end

	// clamp depth to 1..MAX_DEPTH, wrap point is depth - 1
	always_comb begin
		depth_eff = depth_q;
		if (depth_q == '0)
			depth_eff = DEPTH_W'(1);
		if (depth_q > DEPTH_W'(MAX_DEPTH))
			depth_eff = DEPTH_W'(MAX_DEPTH);
	end
	assign last = PTR_W'(depth_eff - DEPTH_W'(1));

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign exec_done = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	// head read in the accept cycle
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_s1   <= action;
			data_s1     <= data;
			mem_rd_s1   <= mem[rp_q];
			rd_valid_s1 <= entry_valid_q[rp_q];
		end
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
	end

	assign head    = rd_valid_s1 ? mem_rd_s1 : '0;
	assign wp_prev = (wp_q == '0) ? last : wp_q - PTR_W'(1);

	always_comb begin
		wp_n      = wp_q;
		rp_n      = rp_q;
		wrapped_n = wrapped_q;
		ovw_n     = ovw_q;
		ack_n     = ack_q;
		exc_n     = exc_q;
		rd_n      = '0;
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = data_s1;
		wp_prev_n = wp_prev;
		case (action_s1)
			ACT_WRITE: begin
				if (data_s1 != '0) begin
					mem_we = exec_done;
					if (wp_q >= last) begin
						wp_n      = '0;
						wrapped_n = 1'b1;
					end else begin
						wp_n = wp_q + PTR_W'(1);
					end
					if (rp_q == wp_n && wrapped_n) begin
						wrapped_n = 1'b0;
						ovw_n     = 1'b1;
					end
					wp_prev_n = (wp_n == '0) ? last : wp_n - PTR_W'(1);
					// oldest entry lost: push the read side forward
					if (ovw_n && rp_q == wp_prev_n) begin
						rp_n  = (rp_q < last) ? rp_q + PTR_W'(1) : '0;
						ack_n = 1'b0;
						exc_n = exc_en_q;
					end
				end
			end
			ACT_READ: begin
				if (ack_q) begin
					ack_n = 1'b0;
					if (exc_q) begin
						exc_n = 1'b0;
						rd_n  = EXC_CODE;
					end else begin
						rd_n      = head;
						mem_we    = exec_done;
						mem_waddr = rp_q;
						mem_wdata = '0;
						rp_n      = (rp_q < last) ? rp_q + PTR_W'(1) : '0;
						if (rp_n == wp_prev)
							ovw_n = 1'b0;
					end
				end else if (exc_q) begin
					ack_n = 1'b1;
					rd_n  = EXC_CODE;
				end else begin
					rd_n = head;
					if (head != '0)
						ack_n = 1'b1;
				end
			end
			ACT_CANCEL: begin
				ack_n = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wp_q          <= '0;
			rp_q          <= '0;
			wrapped_q     <= 1'b0;
			ovw_q         <= 1'b0;
			ack_q         <= 1'b0;
			exc_q         <= 1'b0;
			entry_valid_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_done) begin
						state_q     <= ST_IDLE;
						wp_q        <= wp_n;
						rp_q        <= rp_n;
						wrapped_q   <= wrapped_n;
						ovw_q       <= ovw_n;
						ack_q       <= ack_n;
						exc_q       <= exc_n;
						out_valid_q <= 1'b1;
						if (mem_we)
							entry_valid_q[mem_waddr] <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (exec_done) begin
			read_data_q   <= rd_n;
			has_data_q    <= !(wp_n == rp_n && !ovw_n);
			ack_pending_q <= ack_n;
			exc_pending_q <= exc_n;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_data         = read_data_q;
	assign has_data          = has_data_q;
	assign ack_pending       = ack_pending_q;
	assign exception_pending = exc_pending_q;

endmodule

// ===== tb/sv/ooaf_scoreboard.sv =====
// Result predictor and checker for overwrite_oldest_ack_fifo_unit.
// Watches the register port and both channels; depends on ooaf_pkg.
`timescale 1ns / 1ps

module ooaf_scoreboard (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [ooaf_pkg::PADDR_W-1:0]  paddr,
	input  logic [ooaf_pkg::PDATA_W-1:0]  pwdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [ooaf_pkg::ACTION_W-1:0] action,
	input  logic [ooaf_pkg::DATA_W-1:0]   data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [ooaf_pkg::DATA_W-1:0]   read_data,
	input  logic                          has_data,
	input  logic                          ack_pending,
	input  logic                          exception_pending,
	output int                            failures,
	output int                            outstanding
);
	import ooaf_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              has_data;
		logic              ack_pending;
		logic              exception_pending;
	} fifo_result_t;

	// shadow of the FIFO state and its registers
	logic [DATA_W-1:0]  entry_copy [MAX_DEPTH];
	logic [PTR_W-1:0]   wr_ptr;
	logic [PTR_W-1:0]   rd_ptr;
	logic               wrapped;
	logic               overwritten;
	logic               ack_armed;
	logic               exc_raised;
	logic [DEPTH_W-1:0] depth_reg;
	logic               exc_enable;

	fifo_result_t expected_results[$];

	initial begin
		failures    = 0;
		outstanding = 0;
	end

	// out-of-range depth settings clamp to 1..MAX_DEPTH
	function automatic logic [PTR_W-1:0] last_slot();
		logic [DEPTH_W-1:0] d;
		d = depth_reg;
		if (d == '0)
			d = DEPTH_W'(1);
		if (d > DEPTH_W'(MAX_DEPTH))
			d = DEPTH_W'(MAX_DEPTH);
		return PTR_W'(d - DEPTH_W'(1));
	endfunction

	function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p, logic [PTR_W-1:0] last);
		return (p < last) ? p + 1'b1 : '0;
	endfunction

	function automatic logic [PTR_W-1:0] prev_slot(logic [PTR_W-1:0] p, logic [PTR_W-1:0] last);
		return (p == '0) ? last : p - 1'b1;
	endfunction

	function automatic fifo_result_t apply_transfer(logic [ACTION_W-1:0] act,
			logic [DATA_W-1:0] val);
		fifo_result_t res;
		logic [PTR_W-1:0] last;
		logic [DATA_W-1:0] rd;
		last = last_slot();
		rd = '0;
		case (act)
			ACT_WRITE: begin
				if (val != '0) begin
					entry_copy[wr_ptr] = val;
					if (wr_ptr >= last) begin
						wr_ptr  = '0;
						wrapped = 1'b1;
					end else begin
						wr_ptr = wr_ptr + 1'b1;
					end
					if (rd_ptr == wr_ptr && wrapped) begin
						wrapped     = 1'b0;
						overwritten = 1'b1;
					end
					// oldest entry lost: read side is pushed forward
					if (overwritten && rd_ptr == prev_slot(wr_ptr, last)) begin
						rd_ptr     = next_slot(rd_ptr, last);
						ack_armed  = 1'b0;
						exc_raised = exc_enable;
					end
				end
			end
			ACT_READ: begin
				if (ack_armed) begin
					ack_armed = 1'b0;
					if (exc_raised) begin
						// acknowledge of the exception leaves the entry in place
						exc_raised = 1'b0;
						rd = EXC_CODE;
					end else begin
						rd = entry_copy[rd_ptr];
						entry_copy[rd_ptr] = '0;
						rd_ptr = next_slot(rd_ptr, last);
						if (rd_ptr == prev_slot(wr_ptr, last))
							overwritten = 1'b0;
					end
				end else if (exc_raised) begin
					ack_armed = 1'b1;
					rd = EXC_CODE;
				end else begin
					rd = entry_copy[rd_ptr];
					if (rd != '0)
						ack_armed = 1'b1;
				end
			end
			ACT_CANCEL: begin
				ack_armed = 1'b0;
			end
			default: ;
		endcase
		res.read_data         = rd;
		res.has_data          = !(wr_ptr == rd_ptr && !overwritten);
		res.ack_pending       = ack_armed;
		res.exception_pending = exc_raised;
		return res;
	endfunction

	// everything is sampled mid-cycle, where the channels are stable
	always @(negedge clk) begin
		fifo_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_DEPTH; i++)
				entry_copy[i] = '0;
			wr_ptr      = '0;
			rd_ptr      = '0;
			wrapped     = 1'b0;
			overwritten = 1'b0;
			ack_armed   = 1'b0;
			exc_raised  = 1'b0;
			depth_reg   = DEPTH_RESET;
			exc_enable  = 1'b1;
			expected_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_DEPTH)
					depth_reg = pwdata[DEPTH_W-1:0];
				else
					exc_enable = pwdata[0];
			end
			// output transfer first: the result register sits between a transfer and its result
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					failures++;
				end else begin
					want = expected_results.pop_front();
					if (read_data !== want.read_data) begin
						$error("read_data: expected %0h, got %0h", want.read_data, read_data);
						failures++;
					end
					if (has_data !== want.has_data) begin
						$error("has_data: expected %0b, got %0b", want.has_data, has_data);
						failures++;
					end
					if (ack_pending !== want.ack_pending) begin
						$error("ack_pending: expected %0b, got %0b",
							want.ack_pending, ack_pending);
						failures++;
					end
					if (exception_pending !== want.exception_pending) begin
						$error("exception_pending: expected %0b, got %0b",
							want.exception_pending, exception_pending);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_transfer(action, data));
		end
		outstanding = expected_results.size();
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the overwrite_oldest_ack_fifo_unit testbench: clock, reset, stimulus.
// Depends on ooaf_pkg, the unit and ooaf_scoreboard.
`timescale 1ns / 1ps

module testbench;
	import ooaf_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [ACTION_W-1:0] action = ACT_READ;
	logic [DATA_W-1:0]   data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DATA_W-1:0]   read_data;
	logic                has_data;
	logic                ack_pending;
	logic                exception_pending;

	int failures;
	int outstanding;
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_run = 0;

	overwrite_oldest_ack_fifo_unit DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.action            (action),
		.data              (data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.read_data         (read_data),
		.has_data          (has_data),
		.ack_pending       (ack_pending),
		.exception_pending (exception_pending)
	);

	ooaf_scoreboard scoreboard (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.pready            (pready),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.action            (action),
		.data              (data),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.read_data         (read_data),
		.has_data          (has_data),
		.ack_pending       (ack_pending),
		.exception_pending (exception_pending),
		.failures          (failures),
		.outstanding       (outstanding)
	);

	always #2 clk = ~clk;

	// receiver: free-flowing, random or mostly-stalled stretches
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_run  <= $urandom_range(8, 60);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// called right after a rising edge; returns at the edge of the transfer
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val);
		in_valid <= 1'b1;
		action   <= act;
		data     <= val;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input int depth, input logic exc_en);
		wait_drained();
		write_reg(REG_DEPTH, PDATA_W'(depth));
		@(posedge clk);
		write_reg(REG_EXC_EN, PDATA_W'(exc_en));
	endtask

	function automatic logic [DATA_W-1:0] pick_byte();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return EXC_CODE;
		return DATA_W'($urandom_range(1, 255));
	endfunction

	// bursts of transfers with random gaps; reads mostly come as read + acknowledge
	task automatic run_phase(input int n_items, input int write_pct);
		int sent;
		int burst;
		int gap;
		int r;
		bit dense;
		logic [DATA_W-1:0] b;
		sent  = 0;
		dense = ($urandom_range(0, 3) == 0);
		while (sent < n_items) begin
			gap = (dense || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst = $urandom_range(1, 16);
			repeat (burst) begin
				if ($urandom_range(0, 99) < write_pct) begin
					b = pick_byte();
					send_item(ACT_WRITE, b);
					if (b != '0)
						sent++;
				end else begin
					r = $urandom_range(0, 19);
					if (r == 0) begin
						send_item(ACT_CANCEL, DATA_W'($urandom_range(0, 255)));
						sent++;
					end else if (r == 1) begin
						send_item(ACT_UNUSED, DATA_W'($urandom_range(0, 255)));
					end else if (r == 2) begin
						send_item(ACT_READ, DATA_W'($urandom_range(0, 255)));
						sent++;
					end else begin
						send_item(ACT_READ, DATA_W'($urandom_range(0, 255)));
						send_item(ACT_READ, DATA_W'($urandom_range(0, 255)));
						sent += 2;
					end
				end
			end
		end
	endtask

	int phase_depth[11] = '{1, 2, 3, 0, 511, 256, 5, 300, 4, 17, 256};
	bit phase_exc[11]   = '{1, 0, 1, 1, 0, 1, 0, 1, 0, 1, 1};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty read, ignored zero, cancel, unused action, full range bytes
		send_item(ACT_READ, 8'h00);
		send_item(ACT_WRITE, 8'h00);
		send_item(ACT_WRITE, 8'hFF);
		send_item(ACT_WRITE, 8'h01);
		send_item(ACT_READ, 8'hFF);
		send_item(ACT_CANCEL, 8'h00);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h55);
		send_item(ACT_UNUSED, 8'hAA);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_WRITE, EXC_CODE);
		send_item(ACT_WRITE, 8'h80);
		send_item(ACT_WRITE, 8'h7F);

		// shrink while in use, then overflow to raise the exception
		set_mode(2, 1'b1);
		send_item(ACT_WRITE, 8'h11);
		send_item(ACT_WRITE, 8'h22);
		send_item(ACT_WRITE, 8'h33);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_WRITE, 8'h44);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_READ, 8'h00);
		send_item(ACT_CANCEL, 8'hFF);

		foreach (phase_depth[i]) begin
			set_mode(phase_depth[i], phase_exc[i]);
			// the explicit 256-depth phase is write-heavy to wrap all 256 entries
			if (i == 5)
				run_phase(300, 90);
			else
				run_phase(45, $urandom_range(25, 75));
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
